[hdl/dsif_pkg.sv]
// ----------------------------------------------------------------------------
// dsif_pkg
// Shared constants and types for the binary64 integer/fraction splitter.
// ----------------------------------------------------------------------------
package dsif_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned MANT_W = 52;
    localparam int unsigned EXP_W  = 11;
    localparam int unsigned POS_W  = 6;

    localparam logic [EXP_W-1:0]  EXP_MAX  = 11'h7FF;
    localparam logic [EXP_W-1:0]  EXP_BIAS = 11'd1023;
    localparam logic [MANT_W-1:0] MANT_ONE = 52'd1;

    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        CASE_SPECIAL = 2'd0,
        CASE_NORMAL  = 2'd1
    } case_t;

endpackage

[hdl/double_split_int_frac_core.sv]
// ----------------------------------------------------------------------------
// double_split_int_frac_core
// Splits a binary64 value into its truncated integer part and exact fraction.
// ----------------------------------------------------------------------------
// Four-stage pipeline that accepts one operand per cycle while not stalled
// and presents its result from the stage four registers. A stage stalls only
// while every stage after it is full and the result is not taken. Stage one
// classifies the operand and builds the fraction mask, stage two finds the
// position of the top set bit of the fraction, stage three shifts it into
// place and stage four holds the result until transferred.
module double_split_int_frac_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 x_bits_valid,
    output logic                 x_bits_ready,
    input  dsif_pkg::word_t      x_bits,
    output logic                 out_valid,
    input  logic                 out_ready,
    output dsif_pkg::word_t      int_bits,
    output dsif_pkg::word_t      frac_bits_out
);
    import dsif_pkg::*;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s1_vld_next, s2_vld_next, s3_vld_next, s4_vld_next;
    logic adv1, adv2, adv3, adv4;

    // Stage 1 registers.
    word_t              s1_ip_reg, s1_fr_reg;
    logic               s1_norm_reg;
    logic [MANT_W-1:0]  s1_fm_reg;
    logic [POS_W-1:0]   s1_fb_reg;
    // Stage 2 registers.
    word_t              s2_ip_reg, s2_fr_reg;
    logic               s2_norm_reg;
    logic [MANT_W-1:0]  s2_fm_reg;
    logic [POS_W-1:0]   s2_fb_reg, s2_p_reg;
    // Stage 3/4 registers.
    word_t              s3_ip_reg, s3_fr_reg;
    word_t              s4_ip_reg, s4_fr_reg;

    assign adv4 = ~s4_vld_reg | out_ready;
    assign adv3 = ~s3_vld_reg | adv4;
    assign adv2 = ~s2_vld_reg | adv3;
    assign adv1 = ~s1_vld_reg | adv2;
    assign x_bits_ready = adv1;

    assign s1_vld_next = adv1 ? x_bits_valid : s1_vld_reg;
    assign s2_vld_next = adv2 ? s1_vld_reg : s2_vld_reg;
    assign s3_vld_next = adv3 ? s2_vld_reg : s3_vld_reg;
    assign s4_vld_next = adv4 ? s3_vld_reg : s4_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= s1_vld_next;
            s2_vld_reg <= s2_vld_next;
            s3_vld_reg <= s3_vld_next;
            s4_vld_reg <= s4_vld_next;
        end
    end

    // Stage 1: classify and mask.
    word_t             sgn_w;
    logic [EXP_W-1:0]  ef, e;
    logic [MANT_W-1:0] mant, low;
    logic [POS_W-1:0]  fb;
    word_t             ip_next, fr_next;
    logic              norm_next;

    always_comb
    begin
        sgn_w     = {x_bits[WORD_W-1], {(WORD_W-1){1'b0}}};
        ef        = x_bits[WORD_W-2 -: EXP_W];
        mant      = x_bits[MANT_W-1:0];
        e         = ef - EXP_BIAS;
        fb        = POS_W'(MANT_W) - e[POS_W-1:0];
        low       = (MANT_ONE << fb) - MANT_ONE;
        ip_next   = x_bits;
        fr_next   = sgn_w;
        norm_next = 1'b0;
        if (ef == EXP_MAX)
        begin
            fr_next = (mant != '0) ? x_bits : sgn_w;
        end
        else if (ef < EXP_BIAS)
        begin
            ip_next = sgn_w;
            fr_next = x_bits;
        end
        else if (e >= EXP_W'(MANT_W))
        begin
            fr_next = sgn_w;
        end
        else
        begin
            ip_next   = x_bits & ~{{(WORD_W-MANT_W){1'b0}}, low};
            norm_next = (mant & low) != '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_ip_reg   <= ip_next;
            s1_fr_reg   <= fr_next;
            s1_norm_reg <= norm_next;
            s1_fm_reg   <= mant & low;
            s1_fb_reg   <= fb;
        end
    end

    // Stage 2: position of the top set bit.
    logic [POS_W-1:0] p_next;
    always_comb
    begin
        p_next = '0;
        for (int i = 0; i < MANT_W; i++)
        begin
            if (s1_fm_reg[i])
            begin
                p_next = POS_W'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_ip_reg   <= s1_ip_reg;
            s2_fr_reg   <= s1_fr_reg;
            s2_norm_reg <= s1_norm_reg;
            s2_fm_reg   <= s1_fm_reg;
            s2_fb_reg   <= s1_fb_reg;
            s2_p_reg    <= p_next;
        end
    end

    // Stage 3: renormalize the fraction.
    logic [EXP_W-1:0]  be;
    logic [MANT_W-1:0] m;
    always_comb
    begin
        be = EXP_BIAS + EXP_W'(s2_p_reg) - EXP_W'(s2_fb_reg);
        m  = s2_fm_reg << (POS_W'(MANT_W) - s2_p_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_ip_reg <= s2_ip_reg;
            s3_fr_reg <= s2_norm_reg ? {s2_fr_reg[WORD_W-1], be, m} : s2_fr_reg;
        end
        if (adv4)
        begin
            s4_ip_reg <= s3_ip_reg;
            s4_fr_reg <= s3_fr_reg;
        end
    end

    assign out_valid     = s4_vld_reg;
    assign int_bits      = s4_ip_reg;
    assign frac_bits_out = s4_fr_reg;

endmodule

[hdl/dsif_checker.sv]
// ----------------------------------------------------------------------------
// dsif_checker
// Port-level checks for the binary64 integer/fraction splitter.
// ----------------------------------------------------------------------------
module dsif_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            x_bits_valid,
    input logic            x_bits_ready,
    input dsif_pkg::word_t x_bits,
    input logic            out_valid,
    input logic            out_ready,
    input dsif_pkg::word_t int_bits,
    input dsif_pkg::word_t frac_bits_out
);

    // A stalled result must hold.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(int_bits)
            && $stable(frac_bits_out))
        else $error("result changed while stalled");

    // Both parts always carry the sign of the operand.
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> int_bits[63] == frac_bits_out[63])
        else $error("sign mismatch between parts");

    // Input is ready whenever the output side takes data.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> x_bits_ready)
        else $error("input stalled while output drains");

    // Nothing comes out of an empty pipeline.
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(x_bits_valid, 4) && !$past(x_bits_valid, 5) && !$past(x_bits_valid, 6)
            && !$past(x_bits_valid, 7) && !$past(out_valid) |-> !out_valid)
        else $error("result without operand");

endmodule

bind double_split_int_frac_core dsif_checker u_dsif_checker (.*);

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the binary64 integer/fraction splitter.
// ----------------------------------------------------------------------------
// Random and directed binary64 operands are sent with random gaps. Each
// accepted operand's split is predicted and compared, in order, with the
// transferred results. The receiver stalls at random, and once it holds off
// for a long stretch so that the pipeline fills up.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import dsif_pkg::*;

    localparam int NUM_RANDOM = 1750;
    localparam int WATCHDOG_LIMIT = 20000;

    class split_scoreboard;
        word_t exp_int[$];
        word_t exp_frac[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function void note_operand(word_t x);
            logic [63:0] sgn;
            logic [10:0] ef;
            logic [51:0] mant;
            logic [51:0] low;
            logic [51:0] fm;
            logic [63:0] ip;
            logic [63:0] fr;
            int e;
            int fb;
            int p;
            logic [10:0] be;
            logic [51:0] m;
            sgn = {x[63], 63'd0};
            ef = x[62:52];
            mant = x[51:0];
            if (ef == EXP_MAX)
            begin
                ip = x;
                fr = (mant != 0) ? x : sgn;
            end
            else if (ef < EXP_BIAS)
            begin
                ip = sgn;
                fr = x;
            end
            else if (int'(ef) - 1023 >= 52)
            begin
                ip = x;
                fr = sgn;
            end
            else
            begin
                e = int'(ef) - 1023;
                fb = 52 - e;
                low = (52'd1 << fb) - 52'd1;
                fm = mant & low;
                ip = x & ~{12'd0, low};
                if (fm == 0)
                begin
                    fr = sgn;
                end
                else
                begin
                    p = 0;
                    for (int i = 0; i < 52; i++)
                    begin
                        if (fm[i])
                        begin
                            p = i;
                        end
                    end
                    be = 11'(1023 + p - fb);
                    m = fm << (52 - p);
                    fr = sgn | {1'b0, be, m};
                end
            end
            exp_int.push_back(ip);
            exp_frac.push_back(fr);
        endfunction

        function void check_split(word_t ip, word_t fr);
            word_t ei;
            word_t ef;
            if (exp_int.size() == 0)
            begin
                $display("%0t: unexpected result int=%h frac=%h", $time, ip, fr);
                errors++;
                return;
            end
            ei = exp_int.pop_front();
            ef = exp_frac.pop_front();
            if (ip !== ei)
            begin
                $display("%0t: int_bits expected %h actual %h", $time, ei, ip);
                errors++;
            end
            if (fr !== ef)
            begin
                $display("%0t: frac_bits_out expected %h actual %h", $time, ef, fr);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic x_bits_valid;
    logic x_bits_ready;
    word_t x_bits;
    logic out_valid;
    logic out_ready;
    word_t int_bits;
    word_t frac_bits_out;

    split_scoreboard sb;
    bit send_done;
    bit calm;
    bit held;
    int hold_off;
    int idle_cycles;

    double_split_int_frac_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_bits_valid (x_bits_valid),
        .x_bits_ready (x_bits_ready),
        .x_bits       (x_bits),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .int_bits     (int_bits),
        .frac_bits_out(frac_bits_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic send_operand(input word_t x);
        while (!calm && $urandom_range(99) < 29)
        begin
            x_bits_valid <= 1'b0;
            @(posedge clk);
        end
        x_bits_valid <= 1'b1;
        x_bits <= x;
        do
        begin
            @(posedge clk);
        end
        while (!x_bits_ready);
        sb.note_operand(x);
    endtask

    function automatic word_t random_operand();
        word_t x;
        int unsigned sel;
        x = {$urandom, $urandom};
        sel = $urandom_range(9);
        if (sel < 6)
        begin
            x[62:52] = 11'(1023 + $urandom_range(51));
        end
        else if (sel == 6)
        begin
            x[62:52] = 11'(1023 + 52 + $urandom_range(3));
        end
        else if (sel == 7)
        begin
            x[62:52] = 11'($urandom_range(1022));
        end
        else if (sel == 8)
        begin
            x[62:52] = EXP_MAX;
            if ($urandom_range(1) == 0)
            begin
                x[51:0] = '0;
            end
        end
        if ($urandom_range(7) == 0)
        begin
            x[51:0] = x[51:0] & ({52{1'b1}} << $urandom_range(51));
        end
        return x;
    endfunction

    initial
    begin
        word_t directed[$];
        sb = new();
        rst_n = 1'b0;
        x_bits_valid = 1'b0;
        x_bits = '0;
        send_done = 1'b0;
        calm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed = '{64'h0000000000000000, 64'h8000000000000000, 64'h0000000000000001,
                     64'h800FFFFFFFFFFFFF, 64'h3FEFFFFFFFFFFFFF, 64'h3FF0000000000000,
                     64'hBFF0000000000001, 64'h3FF8000000000000, 64'h4000000000000001,
                     64'h432FFFFFFFFFFFFF, 64'hC32FFFFFFFFFFFFF, 64'h4330000000000000,
                     64'hC33FFFFFFFFFFFFF, 64'h7FEFFFFFFFFFFFFF, 64'h7FF0000000000000,
                     64'hFFF0000000000000, 64'h7FF8000000000000, 64'hFFF0000000000001,
                     64'h400921FB54442D18, 64'hC0934A4584000000, 64'hFFFFFFFFFFFFFFFF,
                     64'h4327FFFFFFFFFFFF, 64'h4024000000000000};
        foreach (directed[i])
        begin
            send_operand(directed[i]);
        end
        for (int i = 0; i < NUM_RANDOM; i++)
        begin
            calm = (i >= 600 && i < 850);
            send_operand(random_operand());
        end
        x_bits_valid <= 1'b0;
        calm = 1'b0;
        send_done = 1'b1;
    end

    initial
    begin
        out_ready = 1'b0;
        hold_off = 0;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                sb.check_split(int_bits, frac_bits_out);
            end
            if (hold_off > 0)
            begin
                hold_off--;
                out_ready <= 1'b0;
            end
            else if (calm && !held)
            begin
                held = 1'b1;
                hold_off = 60;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 29);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((x_bits_valid && x_bits_ready) || (out_valid && out_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
            if (send_done && sb.exp_int.size() == 0)
            begin
                repeat (20) @(posedge clk);
                if (sb.errors == 0 && !out_valid)
                begin
                    $display("tb_top: PASS");
                end
                else
                begin
                    if (out_valid)
                    begin
                        $display("%0t: result left over after the last transfer", $time);
                    end
                    $display("tb_top: FAIL");
                end
                $finish;
            end
        end
    end

endmodule
